FILE: hdl/pmi_pkg.sv
// Package: payload types, limb constants and sequencer codes for the modular inverse.
package pmi_pkg;

	localparam int LIMB_W   = 64;
	localparam int HALF_W   = LIMB_W / 2;
	localparam int NLIMBS   = 4;
	localparam int OP_W     = LIMB_W * NLIMBS;
	localparam int OFFSET_W = 60;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 60'd189;

	typedef struct packed {
		logic [LIMB_W-1:0] a_limb3;
		logic [LIMB_W-1:0] a_limb2;
		logic [LIMB_W-1:0] a_limb1;
		logic [LIMB_W-1:0] a_limb0;
	} in_item_t;

	typedef struct packed {
		logic [LIMB_W-1:0] inverse_limb3;
		logic [LIMB_W-1:0] inverse_limb2;
		logic [LIMB_W-1:0] inverse_limb1;
		logic [LIMB_W-1:0] inverse_limb0;
	} out_item_t;

	// Modular multiplier sequencer states
	typedef enum logic [7:0] {
		MM_IDLE = 8'b00000001,
		MM_MUL  = 8'b00000010,
		MM_FOLD = 8'b00000100,
		MM_TOP  = 8'b00001000,
		MM_ADD  = 8'b00010000,
		MM_WRAP = 8'b00100000,
		MM_FIN  = 8'b01000000,
		MM_DONE = 8'b10000000
	} mm_state_t;

	// Exponentiation sequencer states
	typedef enum logic [7:0] {
		EX_IDLE  = 8'b00000001,
		EX_G0    = 8'b00000010,
		EX_SQ    = 8'b00000100,
		EX_TBL   = 8'b00001000,
		EX_SCAN  = 8'b00010000,
		EX_SQR   = 8'b00100000,
		EX_WMUL  = 8'b01000000,
		EX_OUT   = 8'b10000000
	} ex_state_t;

endpackage

FILE: hdl/pmi_modmul.sv
// Modular multiplier mod 2^256 - c: one 32x32 multiplier reused over quarter products and folding.
module pmi_modmul
	import pmi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     x,
	input  logic [OP_W-1:0]     y,
	input  logic [OFFSET_W-1:0] c,
	output logic                done,
	output logic [OP_W-1:0]     r
);

	mm_state_t state_q;
	logic [1:0] i_q, j_q, h_q;
	logic [LIMB_W-1:0] t_q [8];
	logic [LIMB_W-1:0] carry_q;
	logic [OP_W-1:0] x_q, y_q, u_q;
	logic [2*LIMB_W-1:0] pacc_q;
	logic [OP_W:0] sum_w;

	logic [LIMB_W-1:0] ma, mb;
	logic [HALF_W-1:0] ha, hb;
	logic [LIMB_W-1:0] pp;
	logic [2*LIMB_W-1:0] pp_sh;
	logic [LIMB_W:0] base;
	logic [2*LIMB_W:0] acc;
	logic [2:0] ij;
	logic last_w;

	assign ij = {1'b0, i_q} + {1'b0, j_q};
	assign last_w = (h_q == 2'd3);

	// each 64x64 product is built from four 32x32 quarters, low quarter first
	always_comb begin
		ma = '0;
		mb = '0;
		base = '0;
		case (state_q)
			MM_MUL: begin
				ma = x_q[i_q*LIMB_W +: LIMB_W];
				mb = y_q[j_q*LIMB_W +: LIMB_W];
				base = {1'b0, t_q[ij]} + {1'b0, carry_q};
			end
			MM_FOLD: begin
				ma = t_q[{1'b1, j_q}];
				mb = {{(LIMB_W-OFFSET_W){1'b0}}, c};
				base = {1'b0, t_q[{1'b0, j_q}]} + {1'b0, carry_q};
			end
			MM_TOP: begin
				ma = carry_q;
				mb = {{(LIMB_W-OFFSET_W){1'b0}}, c};
			end
			default: begin
				ma = '0;
				mb = '0;
				base = '0;
			end
		endcase
		ha = h_q[1] ? ma[LIMB_W-1:HALF_W] : ma[HALF_W-1:0];
		hb = h_q[0] ? mb[LIMB_W-1:HALF_W] : mb[HALF_W-1:0];
		pp = ha * hb;
		case (h_q)
			2'd0:    pp_sh = {{LIMB_W{1'b0}}, pp};
			2'd3:    pp_sh = {pp, {LIMB_W{1'b0}}};
			default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
		endcase
		acc = (h_q == 2'd0) ? {{LIMB_W{1'b0}}, base} + {1'b0, pp_sh}
		                    : {1'b0, pacc_q} + {1'b0, pp_sh};
	end

	// top*c plus u; also used as the final conditional add of c
	always_comb begin
		case (state_q)
			MM_ADD:  sum_w = {1'b0, u_q} + {{(OP_W-2*LIMB_W+1){1'b0}}, pacc_q};
			default: sum_w = {1'b0, u_q} + {{(OP_W-OFFSET_W+1){1'b0}}, c};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			i_q <= '0;
			j_q <= '0;
			h_q <= '0;
		end else begin
			case (state_q)
				MM_IDLE: if (start) begin
					state_q <= MM_MUL;
					i_q <= '0;
					j_q <= '0;
					h_q <= '0;
				end
				MM_MUL: begin
					h_q <= h_q + 2'd1;
					if (last_w) begin
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3) begin
							i_q <= i_q + 2'd1;
							if (i_q == 2'd3) state_q <= MM_FOLD;
						end
					end
				end
				MM_FOLD: begin
					h_q <= h_q + 2'd1;
					if (last_w) begin
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3) state_q <= MM_TOP;
					end
				end
				MM_TOP: begin
					h_q <= h_q + 2'd1;
					if (last_w) state_q <= MM_ADD;
				end
				MM_ADD:  state_q <= MM_WRAP;
				MM_WRAP: state_q <= MM_FIN;
				MM_FIN:  state_q <= MM_DONE;
				MM_DONE: state_q <= MM_IDLE;
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MM_IDLE: if (start) begin
				x_q <= x;
				y_q <= y;
				carry_q <= '0;
				for (int k = 0; k < 8; k++) t_q[k] <= '0;
			end
			MM_MUL: begin
				pacc_q <= acc[2*LIMB_W-1:0];
				if (last_w) begin
					t_q[ij] <= acc[LIMB_W-1:0];
					if (j_q == 2'd3) begin
						t_q[ij + 3'd1] <= acc[2*LIMB_W-1:LIMB_W];
						carry_q <= '0;
					end else begin
						carry_q <= acc[2*LIMB_W-1:LIMB_W];
					end
				end
			end
			MM_FOLD: begin
				pacc_q <= acc[2*LIMB_W-1:0];
				if (last_w) begin
					u_q[j_q*LIMB_W +: LIMB_W] <= acc[LIMB_W-1:0];
					carry_q <= acc[2*LIMB_W-1:LIMB_W];
				end
			end
			MM_TOP: begin
				pacc_q <= acc[2*LIMB_W-1:0];
			end
			MM_ADD: begin
				u_q <= sum_w[OP_W-1:0];
				carry_q <= {{(LIMB_W-1){1'b0}}, sum_w[OP_W]};
			end
			MM_WRAP: begin
				// add c once more if the fold overflowed
				if (carry_q[0]) u_q <= sum_w[OP_W-1:0];
			end
			MM_FIN: begin
				if (sum_w[OP_W]) u_q <= sum_w[OP_W-1:0];
			end
			default: ;
		endcase
	end

	assign done = (state_q == MM_DONE);
	assign r = u_q;

endmodule

FILE: hdl/pseudo_mersenne_mod_inverse.sv
// Top level: Fermat inversion mod 2^256 - c by sliding-window exponentiation.
//
// Input channel in_valid/in_ready carries one 256-bit operand as four limbs;
// output channel out_valid/out_ready returns its inverse a^(p-2) mod p, fully
// reduced. A zero operand returns zero. The user must write the offset c
// through cfg_we/cfg_data only while idle; the block does not enforce this.
// One item at a time: in_ready is high only when the block is idle and no
// result is held. Every product goes through one shared modular multiplier
// built on a 32x32 multiplier, which forms the limb products, folds the high
// half, multiplies the top word by c, adds it back, wraps and reduces, then
// signals done before the next operands are handed over. An item takes about
// 330 products plus a scan step per window or zero bit.
// The result sits in an output register until taken; a stalled receiver holds
// the block with the result unchanged and no new item is taken.
// Reset clears all control state and loads c = 189.
// The table of odd powers is a small memory of 2^(WINDOW_BITS-1) entries.
module pseudo_mersenne_mod_inverse
	import pmi_pkg::*;
#(
	parameter int WINDOW_BITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [OFFSET_W-1:0] cfg_data
);

	localparam int TBL_N = 1 << (WINDOW_BITS - 1);
	localparam int TBL_W = (WINDOW_BITS > 1) ? WINDOW_BITS - 1 : 1;
	localparam int WIN_CW = $clog2(WINDOW_BITS + 1);

	ex_state_t state_q;
	logic [OFFSET_W-1:0] c_q, cw_q;
	logic [OP_W-1:0] a_q, sq_q, r_q, g_rd_q;
	logic [OP_W-1:0] g_q [TBL_N];
	logic [TBL_W-1:0] tidx_q;
	logic [7:0] bit_q;
	logic [WIN_CW-1:0] wcnt_q;
	logic [WINDOW_BITS-1:0] wval_q;
	logic out_valid_q;
	logic [OP_W-1:0] exp_w;
	logic [OFFSET_W-1:0] low_w;

	logic mm_start_q;
	logic mm_done;
	logic [OP_W-1:0] mx, my, mr;
	logic mm_busy_q;

	// window scan helpers (combinational, narrow)
	logic [7:0] s_w;
	logic [WINDOW_BITS-1:0] win_w;
	logic [WIN_CW-1:0] wlen_w;

	assign low_w = ~cw_q - {{(OFFSET_W-1){1'b0}}, 1'b1};
	assign exp_w = {{(OP_W-OFFSET_W){1'b1}}, low_w};

	always_comb begin
		logic [8:0] st;
		st = {1'b0, bit_q} - 9'(WINDOW_BITS - 1);
		if (st[8]) st = '0;
		// advance start until its bit is one (bit_q is one, so it stops)
		for (int k = 0; k < WINDOW_BITS; k++) begin
			if (!exp_w[st[7:0]] && st[7:0] < bit_q) st = st + 9'd1;
		end
		s_w = st[7:0];
		win_w = '0;
		for (int k = 0; k < WINDOW_BITS; k++) begin
			if (8'(k) <= bit_q - s_w) win_w[k] = exp_w[s_w + 8'(k)];
		end
		wlen_w = WIN_CW'(bit_q - s_w + 8'd1);
	end

	pmi_modmul u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start_q),
		.x      (mx),
		.y      (my),
		.c      (cw_q),
		.done   (mm_done),
		.r      (mr)
	);

	always_comb begin
		mx = r_q;
		my = r_q;
		case (state_q)
			EX_G0:   begin mx = a_q; my = {{(OP_W-1){1'b0}}, 1'b1}; end
			EX_SQ:   begin mx = g_rd_q; my = g_rd_q; end
			EX_TBL:  begin mx = g_rd_q; my = sq_q; end
			EX_WMUL: begin mx = r_q; my = g_rd_q; end
			default: begin mx = r_q; my = r_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			c_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EX_G0 && mm_done) g_q[0] <= mr;
		else if (state_q == EX_TBL && mm_done) g_q[tidx_q + TBL_W'(1)] <= mr;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EX_WMUL: g_rd_q <= g_q[TBL_W'((wval_q - 1'b1) >> 1)];
			default: g_rd_q <= g_q[tidx_q];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			mm_start_q <= 1'b0;
			mm_busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			tidx_q <= '0;
			bit_q <= '0;
			wcnt_q <= '0;
			wval_q <= '0;
		end else begin
			mm_start_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				EX_IDLE: if (in_valid && in_ready) begin
					state_q <= EX_G0;
					mm_start_q <= 1'b1;
					mm_busy_q <= 1'b1;
					tidx_q <= '0;
				end
				EX_G0: if (mm_done) begin
					state_q <= EX_SQ;
					mm_busy_q <= 1'b0;
				end else if (!mm_busy_q) begin
					mm_start_q <= 1'b1;
					mm_busy_q <= 1'b1;
				end
				EX_SQ, EX_TBL: if (mm_done) begin
					mm_busy_q <= 1'b0;
					if (state_q == EX_TBL) tidx_q <= tidx_q + TBL_W'(1);
					if (state_q == EX_SQ && TBL_N > 1) state_q <= EX_TBL;
					else if (state_q == EX_TBL && int'(tidx_q) + 2 < TBL_N)
						state_q <= EX_TBL;
					else begin
						state_q <= EX_SCAN;
						bit_q <= 8'd255;
					end
				end else if (!mm_busy_q && !mm_start_q) begin
					mm_start_q <= 1'b1;
					mm_busy_q <= 1'b1;
				end
				EX_SCAN: begin
					if (exp_w[bit_q]) begin
						wcnt_q <= wlen_w;
						wval_q <= win_w;
						bit_q <= s_w;
					end else begin
						wcnt_q <= WIN_CW'(1);
						wval_q <= '0;
					end
					state_q <= EX_SQR;
				end
				EX_SQR: if (mm_done) begin
					mm_busy_q <= 1'b0;
					if (wcnt_q != WIN_CW'(1)) wcnt_q <= wcnt_q - WIN_CW'(1);
					else if (wval_q != '0) state_q <= EX_WMUL;
					else if (bit_q == 8'd0) state_q <= EX_OUT;
					else begin
						bit_q <= bit_q - 8'd1;
						state_q <= EX_SCAN;
					end
				end else if (!mm_busy_q && !mm_start_q) begin
					mm_start_q <= 1'b1;
					mm_busy_q <= 1'b1;
				end
				EX_WMUL: if (mm_done) begin
					mm_busy_q <= 1'b0;
					if (bit_q == 8'd0) state_q <= EX_OUT;
					else begin
						bit_q <= bit_q - 8'd1;
						state_q <= EX_SCAN;
					end
				end else if (!mm_busy_q && !mm_start_q) begin
					mm_start_q <= 1'b1;
					mm_busy_q <= 1'b1;
				end
				EX_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= EX_IDLE;
				end
				default: state_q <= EX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EX_IDLE && in_valid && in_ready) begin
			a_q <= in_data;
			cw_q <= c_q;
			// r starts at one*one mod p, which is one for any c >= 0
			r_q <= {{(OP_W-1){1'b0}}, 1'b1};
		end
		if (state_q == EX_SQ && mm_done) sq_q <= mr;
		if ((state_q == EX_SQR || state_q == EX_WMUL) && mm_done) r_q <= mr;
	end

	assign in_ready = (state_q == EX_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = r_q;

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n)
			(state_q != EX_IDLE) |-> !in_ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy)
		else $error("input taken while busy");

	property p_out_holds;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && !out_ready) |=> (out_valid && $stable(out_data));
	endproperty
	a_out_holds: assert property (p_out_holds)
		else $error("result changed under stall");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n)
			mm_done |=> !mm_done;
	endproperty
	a_done_pulse: assert property (p_done_pulse)
		else $error("multiplier done held");

endmodule

FILE: tb/testbench.sv
// Testbench for the pseudo-Mersenne modular inverse: directed and random operands checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
	import pmi_pkg::*;

	localparam int WATCHDOG_LIMIT = 150000;
	localparam int WIN = 4;
	localparam int ODD_POWERS = 1 << (WIN - 1);
	localparam logic [OFFSET_W-1:0] OFFSET_LOW  = 60'd1;
	localparam logic [OFFSET_W-1:0] OFFSET_HIGH = 60'hFFF_FFFF_FFFF_FFFE;
	localparam logic [OFFSET_W-1:0] OFFSET_ONES = 60'hFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [OFFSET_W-1:0] cfg_data = '0;

	logic [OFFSET_W-1:0] offset_c = OFFSET_RESET;
	out_item_t inverse_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	pseudo_mersenne_mod_inverse dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// x * y mod 2^256 - c with the block's fold, wrap and final subtract
	function automatic logic [255:0] mulmod(logic [255:0] x, logic [255:0] y,
			logic [OFFSET_W-1:0] c);
		logic [511:0] prod;
		logic [319:0] folded;
		logic [63:0] top;
		logic [256:0] wrapped;
		logic [256:0] trial;
		logic [255:0] u;
		prod = {256'b0, x} * {256'b0, y};
		folded = {64'b0, prod[255:0]} + {4'b0, prod[511:256]} * {260'b0, c};
		top = folded[319:256];
		wrapped = {1'b0, folded[255:0]} + {193'b0, top} * {197'b0, c};
		u = wrapped[255:0];
		if (wrapped[256])
			u = u + {196'b0, c};
		trial = {1'b0, u} + {197'b0, c};
		if (trial[256])
			u = trial[255:0];
		return u;
	endfunction

	function automatic logic [255:0] fermat_inverse(logic [255:0] a, logic [OFFSET_W-1:0] c);
		logic [255:0] odd_pow [ODD_POWERS];
		logic [255:0] sq;
		logic [255:0] r;
		logic [255:0] ex;
		logic [63:0] low;
		int i;
		int s;
		int k;
		int t;
		low = ~{4'b0, c} - 64'd1;
		ex = {{196{1'b1}}, low[59:0]};
		odd_pow[0] = mulmod(a, 256'd1, c);
		sq = mulmod(odd_pow[0], odd_pow[0], c);
		for (k = 1; k < ODD_POWERS; k++)
			odd_pow[k] = mulmod(odd_pow[k-1], sq, c);
		r = mulmod(256'd1, 256'd1, c);
		i = 255;
		while (i >= 0) begin
			if (!ex[i]) begin
				r = mulmod(r, r, c);
				i--;
			end else begin
				s = i - WIN + 1;
				if (s < 0)
					s = 0;
				while (!ex[s])
					s++;
				t = 0;
				for (k = i; k >= s; k--) begin
					t = t * 2 + int'(ex[k]);
					r = mulmod(r, r, c);
				end
				r = mulmod(r, odd_pow[((t - 1) >> 1) & (ODD_POWERS - 1)], c);
				i = s - 1;
			end
		end
		return r;
	endfunction

	// Receiver: random stall, compare every beat with the oldest expectation
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			if (inverse_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				out_item_t want;
				want = inverse_q.pop_front();
				if (out_data.inverse_limb0 !== want.inverse_limb0) begin
					$display("%0t: inverse_limb0 expected %h actual %h", $time,
						want.inverse_limb0, out_data.inverse_limb0);
					errors++;
				end
				if (out_data.inverse_limb1 !== want.inverse_limb1) begin
					$display("%0t: inverse_limb1 expected %h actual %h", $time,
						want.inverse_limb1, out_data.inverse_limb1);
					errors++;
				end
				if (out_data.inverse_limb2 !== want.inverse_limb2) begin
					$display("%0t: inverse_limb2 expected %h actual %h", $time,
						want.inverse_limb2, out_data.inverse_limb2);
					errors++;
				end
				if (out_data.inverse_limb3 !== want.inverse_limb3) begin
					$display("%0t: inverse_limb3 expected %h actual %h", $time,
						want.inverse_limb3, out_data.inverse_limb3);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_operand(logic [255:0] a);
		int gap;
		out_item_t want;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = fermat_inverse(a, offset_c);
		inverse_q.push_back(want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_offset(logic [OFFSET_W-1:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_c = c;
	endtask

	function automatic logic [255:0] rand_operand();
		logic [255:0] v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(7))
			0: v = v >> $urandom_range(255);
			1: v = ~(256'd0) - (v >> 192);
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_operand_extremes();
		logic [255:0] p;
		p = ~(256'd0) - 256'(offset_c) + 256'd1;
		send_operand(256'd0);
		send_operand(256'd1);
		send_operand(256'd2);
		send_operand(~(256'd0));
		send_operand(p);
		send_operand(p - 256'd1);
		send_operand(p + 256'd1);
		send_operand(256'd3);
		send_operand({4{64'h8000_0000_0000_0000}});
		send_operand({4{64'h5555_5555_5555_5555}});
		send_operand({4{64'hAAAA_AAAA_AAAA_AAAA}});
	endtask

	task automatic test_offset_extremes();
		logic [OFFSET_W-1:0] list [4];
		list = '{OFFSET_LOW, OFFSET_HIGH, '0, OFFSET_ONES};
		foreach (list[n]) begin
			write_offset(list[n]);
			send_operand(256'd0);
			send_operand(~(256'd0));
			send_operand(rand_operand());
		end
		write_offset(OFFSET_RESET);
	endtask

	task automatic test_paused_sender();
		repeat (2) begin
			drain();
			send_operand(rand_operand());
		end
	endtask

	task automatic test_random_operands();
		int phase;
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 49 : 0;
			recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 22 : 0;
			write_offset(phase == 2 ? OFFSET_RESET : OFFSET_W'({$urandom, $urandom}));
			repeat (27) send_operand(rand_operand());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operand_extremes();
		test_offset_extremes();
		test_paused_sender();
		test_random_operands();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
